// File: design/msd_pkg.sv
// Shared types and constants of the priority multi-server dispatcher.
// Used by msd_front, msd_back and the top level; depends on nothing.
package msd_pkg;

   localparam int MAX_SERVERS_DEF = 4;
   localparam int POOL_DEPTH_DEF  = 16;
   localparam int TIME_WIDTH_DEF  = 32;

   localparam int ARRIVAL_W = 32;
   localparam int SERVICE_W = 16;
   localparam int PRIO_W    = 16;
   localparam int INDEX_W   = 16;
   localparam int START_W   = 32;
   localparam int CSR_W     = 3;

   localparam int QUEUE_DEPTH = 2;

   localparam logic FUNC_SUBMIT = 1'b0;
   localparam logic FUNC_FLUSH  = 1'b1;

   localparam logic STATUS_STARTED = 1'b0;
   localparam logic STATUS_DROPPED = 1'b1;

   typedef struct packed {
      logic                 func;
      logic [ARRIVAL_W-1:0] arrival_time;
      logic [SERVICE_W-1:0] service_time;
      logic [PRIO_W-1:0]    priority_req;
      logic [INDEX_W-1:0]   job_index;
   } item_type;

   typedef struct packed {
      logic               status;
      logic [INDEX_W-1:0] job_index;
      logic [START_W-1:0] start_time;
      logic               last;
   } result_type;

   typedef struct packed {
      logic [PRIO_W-1:0]    priority_req;
      logic [SERVICE_W-1:0] service_time;
      logic [INDEX_W-1:0]   job_index;
   } pool_entry_type;

endpackage

// File: design/priority_multi_server_dispatcher_top.sv
// Top level of the priority multi-server dispatcher: config register, front end,
// back end and response register. Depends on msd_pkg, msd_front, msd_back.
//
// Usage:
//   Requests enter on req_* (valid/stall). req_func selects a job submit or a
//   flush; a submit carries arrival time, service time and priority and gets
//   the next job number. Results leave on rsp_* (valid/stall): status, job
//   number, start time and a last flag on the final result of a request. A
//   request that only parks a job, or flushes an empty pool, gives no result.
//   csr_wr_en/csr_wr_data set the number of active servers; write it only
//   while the block is idle.
// Timing:
//   A two-entry request queue takes requests while the back end works. Each
//   decision scans the pool RAM and the server times one entry per cycle,
//   after the request is picked and before it is closed; a request that
//   causes k dispatches scans the pool k + 1 times.
// Reset: synchronous; clears servers, pool, job numbers and time, one server
//   active. A stalled response holds; the back end waits on its held result.
module priority_multi_server_dispatcher_top #(
   parameter int MAX_SERVERS = msd_pkg::MAX_SERVERS_DEF,
   parameter int POOL_DEPTH  = msd_pkg::POOL_DEPTH_DEF,
   parameter int TIME_WIDTH  = msd_pkg::TIME_WIDTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic                             req_func,
   input  logic [msd_pkg::ARRIVAL_W-1:0]    req_arrival_time,
   input  logic [msd_pkg::SERVICE_W-1:0]    req_service_time,
   input  logic [msd_pkg::PRIO_W-1:0]       req_priority_req,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic                             rsp_status,
   output logic [msd_pkg::INDEX_W-1:0]      rsp_job_index,
   output logic [msd_pkg::START_W-1:0]      rsp_start_time,
   output logic                             rsp_last,
   input  logic                             csr_wr_en,
   input  logic [msd_pkg::CSR_W-1:0]        csr_wr_data
);

   localparam int NSRV_W = $clog2(MAX_SERVERS + 1);

   logic [msd_pkg::CSR_W-1:0]   active_servers_ff;
   logic [NSRV_W-1:0]           n_servers;
   logic                        q_valid;
   msd_pkg::item_type           q_item;
   logic                        q_pop;
   logic                        back_valid;
   msd_pkg::result_type         back_item;
   logic                        out_ready;
   logic                        rsp_valid_ff, rsp_valid_in;
   msd_pkg::result_type         rsp_ff;

   // clamp the server count: zero counts as one, cap at the built count
   always_comb begin
      if (active_servers_ff == '0) begin
         n_servers = NSRV_W'(1);
      end else if (int'(active_servers_ff) > MAX_SERVERS) begin
         n_servers = NSRV_W'(MAX_SERVERS);
      end else begin
         n_servers = NSRV_W'(active_servers_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_servers_ff <= msd_pkg::CSR_W'(1);
      end else if (csr_wr_en) begin
         active_servers_ff <= csr_wr_data;
      end
   end

   msd_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_func         (req_func),
      .req_arrival_time (req_arrival_time),
      .req_service_time (req_service_time),
      .req_priority_req (req_priority_req),
      .q_valid          (q_valid),
      .q_item           (q_item),
      .q_pop            (q_pop)
   );

   msd_back #(
      .MAX_SERVERS (MAX_SERVERS),
      .POOL_DEPTH  (POOL_DEPTH),
      .TIME_WIDTH  (TIME_WIDTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .n_servers (n_servers),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .q_pop     (q_pop),
      .out_valid (back_valid),
      .out_item  (back_item),
      .out_ready (out_ready)
   );

   // response register: load when empty or being taken this cycle
   assign out_ready = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_ready) begin
         rsp_valid_in = back_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready && back_valid) begin
         rsp_ff <= back_item;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_ff.status;
   assign rsp_job_index  = rsp_ff.job_index;
   assign rsp_start_time = rsp_ff.start_time;
   assign rsp_last       = rsp_ff.last;

endmodule

// File: design/msd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module msd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data_ff
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

endmodule

// File: design/msd_front.sv
// Front end: accepts requests, numbers submitted jobs, queues them for the back end.
// Depends on msd_pkg.
module msd_front (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_func,
   input  logic [msd_pkg::ARRIVAL_W-1:0]      req_arrival_time,
   input  logic [msd_pkg::SERVICE_W-1:0]      req_service_time,
   input  logic [msd_pkg::PRIO_W-1:0]         req_priority_req,
   output logic                               q_valid,
   output msd_pkg::item_type                  q_item,
   input  logic                               q_pop
);

   localparam int PTR_W = $clog2(msd_pkg::QUEUE_DEPTH);
   localparam int CNT_W = $clog2(msd_pkg::QUEUE_DEPTH + 1);

   msd_pkg::item_type                  queue_ff [msd_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]                   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]                   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]                   count_ff, count_in;
   logic [msd_pkg::INDEX_W-1:0]        job_counter_ff, job_counter_in;
   logic                               push;
   msd_pkg::item_type                  new_item;

   assign req_stall = (count_ff == CNT_W'(msd_pkg::QUEUE_DEPTH));
   assign push      = req_valid && !req_stall;
   assign q_valid   = (count_ff != '0);
   assign q_item    = queue_ff[rd_ptr_ff];

   always_comb begin
      new_item.func         = req_func;
      new_item.arrival_time = req_arrival_time;
      new_item.service_time = req_service_time;
      new_item.priority_req = req_priority_req;
      new_item.job_index    = job_counter_ff;

      wr_ptr_in      = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in      = q_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in       = count_ff + CNT_W'(push) - CNT_W'(q_pop);
      // a flush takes no job number
      job_counter_in = (push && req_func == msd_pkg::FUNC_SUBMIT) ?
                       job_counter_ff + 1'b1 : job_counter_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff      <= '0;
         rd_ptr_ff      <= '0;
         count_ff       <= '0;
         job_counter_ff <= '0;
      end else begin
         wr_ptr_ff      <= wr_ptr_in;
         rd_ptr_ff      <= rd_ptr_in;
         count_ff       <= count_in;
         job_counter_ff <= job_counter_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

// File: design/msd_back.sv
// Back end: scans the waiting pool and the servers, dispatches, inserts or drops jobs.
// Depends on msd_pkg and msd_ram.
module msd_back #(
   parameter int MAX_SERVERS = msd_pkg::MAX_SERVERS_DEF,
   parameter int POOL_DEPTH  = msd_pkg::POOL_DEPTH_DEF,
   parameter int TIME_WIDTH  = msd_pkg::TIME_WIDTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [$clog2(MAX_SERVERS+1)-1:0]   n_servers,
   input  logic                               q_valid,
   input  msd_pkg::item_type                  q_item,
   output logic                               q_pop,
   output logic                               out_valid,
   output msd_pkg::result_type                out_item,
   input  logic                               out_ready
);

   localparam int POOL_W   = $clog2(POOL_DEPTH);
   localparam int SRV_W    = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
   localparam int SCAN_LEN = (POOL_DEPTH > MAX_SERVERS) ? POOL_DEPTH : MAX_SERVERS;
   localparam int CNT_W    = $clog2(SCAN_LEN + 1);
   localparam int ENTRY_W  = $bits(msd_pkg::pool_entry_type);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SCAN   = 4'b0010,
      ST_DECIDE = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

   state_type                       state_ff, state_in;
   logic [CNT_W-1:0]                cnt_ff, cnt_in;
   msd_pkg::item_type               item_ff, item_in;
   logic [TIME_WIDTH-1:0]           cur_time_ff, cur_time_in;
   logic [TIME_WIDTH-1:0]           srv_free_ff [MAX_SERVERS];
   logic [TIME_WIDTH-1:0]           srv_free_in [MAX_SERVERS];
   logic                            pool_valid_ff [POOL_DEPTH];
   logic                            pool_valid_in [POOL_DEPTH];
   logic [POOL_W-1:0]               pool_rank_ff [POOL_DEPTH];
   logic [POOL_W-1:0]               pool_rank_in [POOL_DEPTH];
   logic                            rd_vld_ff, rd_vld_in;
   logic [POOL_W-1:0]               rd_slot_ff, rd_slot_in;
   logic                            best_found_ff, best_found_in;
   logic [msd_pkg::PRIO_W-1:0]      best_pri_ff, best_pri_in;
   logic [POOL_W-1:0]               best_rank_ff, best_rank_in;
   logic [POOL_W-1:0]               best_slot_ff, best_slot_in;
   logic [msd_pkg::INDEX_W-1:0]     best_idx_ff, best_idx_in;
   logic [msd_pkg::SERVICE_W-1:0]   best_svc_ff, best_svc_in;
   logic [TIME_WIDTH-1:0]           srv_t_ff, srv_t_in;
   logic [SRV_W-1:0]                srv_sel_ff, srv_sel_in;
   logic                            free_found_ff, free_found_in;
   logic [POOL_W-1:0]               free_slot_ff, free_slot_in;
   logic                            pend_valid_ff, pend_valid_in;
   msd_pkg::result_type             pend_ff, pend_in;

   logic                            ram_we;
   msd_pkg::pool_entry_type         ram_wdata;
   msd_pkg::pool_entry_type         ram_rdata;
   logic [ENTRY_W-1:0]              ram_rdata_raw;

   logic [TIME_WIDTH-1:0]           arrival_t;
   logic [TIME_WIDTH-1:0]           scan_t;
   logic                            is_flush;
   logic                            dispatch_go;
   logic                            start_now;
   logic                            do_drop;
   logic                            do_insert;
   logic                            produce;
   logic                            advance;

   function automatic logic [TIME_WIDTH-1:0] sat_add(
      input logic [TIME_WIDTH-1:0]         base,
      input logic [msd_pkg::SERVICE_W-1:0] span
   );
      logic [TIME_WIDTH:0] sum;
      sum = {1'b0, base} + (TIME_WIDTH+1)'(span);
      return sum[TIME_WIDTH] ? '1 : sum[TIME_WIDTH-1:0];
   endfunction

   msd_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (POOL_DEPTH)
   ) u_pool_ram (
      .clock      (clock),
      .wr_en      (ram_we),
      .wr_addr    (free_slot_ff),
      .wr_data    (ram_wdata),
      .rd_addr    (cnt_ff[POOL_W-1:0]),
      .rd_data_ff (ram_rdata_raw)
   );

   assign ram_rdata = msd_pkg::pool_entry_type'(ram_rdata_raw);
   assign arrival_t = TIME_WIDTH'(item_ff.arrival_time);
   assign scan_t    = (srv_free_ff[cnt_ff[SRV_W-1:0]] < cur_time_ff) ?
                      cur_time_ff : srv_free_ff[cnt_ff[SRV_W-1:0]];

   always_comb begin
      is_flush    = (item_ff.func == msd_pkg::FUNC_FLUSH);
      dispatch_go = best_found_ff && (is_flush || srv_t_ff < arrival_t);
      start_now   = !is_flush && !best_found_ff && (srv_t_ff < arrival_t);
      do_drop     = !is_flush && !dispatch_go && !start_now && !free_found_ff;
      do_insert   = !is_flush && !dispatch_go && !start_now && free_found_ff;
      produce     = dispatch_go || start_now || do_drop;
      advance     = !produce || !pend_valid_ff || out_ready;
   end

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      item_in       = item_ff;
      cur_time_in   = cur_time_ff;
      srv_free_in   = srv_free_ff;
      pool_valid_in = pool_valid_ff;
      pool_rank_in  = pool_rank_ff;
      rd_vld_in     = 1'b0;
      rd_slot_in    = cnt_ff[POOL_W-1:0];
      best_found_in = best_found_ff;
      best_pri_in   = best_pri_ff;
      best_rank_in  = best_rank_ff;
      best_slot_in  = best_slot_ff;
      best_idx_in   = best_idx_ff;
      best_svc_in   = best_svc_ff;
      srv_t_in      = srv_t_ff;
      srv_sel_in    = srv_sel_ff;
      free_found_in = free_found_ff;
      free_slot_in  = free_slot_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      q_pop         = 1'b0;
      ram_we        = 1'b0;
      out_valid     = 1'b0;
      out_item      = pend_ff;

      ram_wdata.priority_req = item_ff.priority_req;
      ram_wdata.service_time = item_ff.service_time;
      ram_wdata.job_index    = item_ff.job_index;

      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop         = 1'b1;
               item_in       = q_item;
               cnt_in        = '0;
               best_found_in = 1'b0;
               free_found_in = 1'b0;
               state_in      = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cnt_in    = cnt_ff + 1'b1;
            rd_vld_in = (cnt_ff < CNT_W'(POOL_DEPTH));
            // earliest effective free time, lowest server on a tie
            if (cnt_ff < CNT_W'(n_servers)) begin
               if (cnt_ff == '0 || scan_t < srv_t_ff) begin
                  srv_t_in   = scan_t;
                  srv_sel_in = cnt_ff[SRV_W-1:0];
               end
            end
            // slot read last cycle: best job, newest wins on equal priority
            if (rd_vld_ff) begin
               if (pool_valid_ff[rd_slot_ff]) begin
                  if (!best_found_ff || ram_rdata.priority_req > best_pri_ff ||
                      (ram_rdata.priority_req == best_pri_ff &&
                       pool_rank_ff[rd_slot_ff] < best_rank_ff)) begin
                     best_found_in = 1'b1;
                     best_pri_in   = ram_rdata.priority_req;
                     best_rank_in  = pool_rank_ff[rd_slot_ff];
                     best_slot_in  = rd_slot_ff;
                     best_idx_in   = ram_rdata.job_index;
                     best_svc_in   = ram_rdata.service_time;
                  end
               end else if (!free_found_ff) begin
                  free_found_in = 1'b1;
                  free_slot_in  = rd_slot_ff;
               end
            end
            if (cnt_ff == CNT_W'(SCAN_LEN)) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            // a new result pushes the held one out, not marked last
            if (produce && pend_valid_ff) begin
               out_valid = 1'b1;
            end
            if (advance) begin
               if (dispatch_go) begin
                  srv_free_in[srv_sel_ff]     = sat_add(srv_t_ff, best_svc_ff);
                  cur_time_in                 = srv_t_ff;
                  pool_valid_in[best_slot_ff] = 1'b0;
                  for (int j = 0; j < POOL_DEPTH; j++) begin
                     if (pool_valid_ff[j] && pool_rank_ff[j] > best_rank_ff) begin
                        pool_rank_in[j] = pool_rank_ff[j] - 1'b1;
                     end
                  end
                  pend_in.status     = msd_pkg::STATUS_STARTED;
                  pend_in.job_index  = best_idx_ff;
                  pend_in.start_time = msd_pkg::START_W'(srv_t_ff);
                  pend_in.last       = 1'b0;
                  pend_valid_in      = 1'b1;
                  cnt_in             = '0;
                  best_found_in      = 1'b0;
                  free_found_in      = 1'b0;
                  state_in           = ST_SCAN;
               end else begin
                  if (start_now) begin
                     srv_free_in[srv_sel_ff] = sat_add(arrival_t, item_ff.service_time);
                     cur_time_in             = arrival_t;
                     pend_in.status          = msd_pkg::STATUS_STARTED;
                     pend_in.job_index       = item_ff.job_index;
                     pend_in.start_time      = msd_pkg::START_W'(arrival_t);
                     pend_in.last            = 1'b0;
                     pend_valid_in           = 1'b1;
                  end
                  if (do_drop) begin
                     pend_in.status     = msd_pkg::STATUS_DROPPED;
                     pend_in.job_index  = item_ff.job_index;
                     pend_in.start_time = '0;
                     pend_in.last       = 1'b0;
                     pend_valid_in      = 1'b1;
                  end
                  if (do_insert) begin
                     ram_we = 1'b1;
                     for (int j = 0; j < POOL_DEPTH; j++) begin
                        if (pool_valid_ff[j]) begin
                           pool_rank_in[j] = pool_rank_ff[j] + 1'b1;
                        end
                     end
                     pool_valid_in[free_slot_ff] = 1'b1;
                     pool_rank_in[free_slot_ff]  = '0;
                  end
                  state_in = ST_FINISH;
               end
            end
         end
         ST_FINISH: begin
            // release the held result as the last one of this request
            if (pend_valid_ff) begin
               out_valid     = 1'b1;
               out_item.last = 1'b1;
               if (out_ready) begin
                  pend_valid_in = 1'b0;
                  state_in      = ST_IDLE;
               end
            end else begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cnt_ff        <= '0;
         cur_time_ff   <= '0;
         rd_vld_ff     <= 1'b0;
         best_found_ff <= 1'b0;
         free_found_ff <= 1'b0;
         pend_valid_ff <= 1'b0;
         for (int s = 0; s < MAX_SERVERS; s++) begin
            srv_free_ff[s] <= '0;
         end
         for (int j = 0; j < POOL_DEPTH; j++) begin
            pool_valid_ff[j] <= 1'b0;
            pool_rank_ff[j]  <= '0;
         end
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         cur_time_ff   <= cur_time_in;
         rd_vld_ff     <= rd_vld_in;
         best_found_ff <= best_found_in;
         free_found_ff <= free_found_in;
         pend_valid_ff <= pend_valid_in;
         srv_free_ff   <= srv_free_in;
         pool_valid_ff <= pool_valid_in;
         pool_rank_ff  <= pool_rank_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff      <= item_in;
      rd_slot_ff   <= rd_slot_in;
      best_pri_ff  <= best_pri_in;
      best_rank_ff <= best_rank_in;
      best_slot_ff <= best_slot_in;
      best_idx_ff  <= best_idx_in;
      best_svc_ff  <= best_svc_in;
      srv_t_ff     <= srv_t_in;
      srv_sel_ff   <= srv_sel_in;
      free_slot_ff <= free_slot_in;
      pend_ff      <= pend_in;
   end

   a_finish_drains: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && out_ready) |=> !pend_valid_ff)
      else $error("held result not released at end of request");

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (cnt_ff <= CNT_W'(SCAN_LEN)))
      else $error("scan counter ran past its end");

   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> (q_valid && state_ff == ST_IDLE))
      else $error("queue popped while empty or busy");

   a_dispatch_found: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DECIDE && dispatch_go && advance) |=> !pool_valid_ff[$past(best_slot_ff)])
      else $error("dispatched slot still marked waiting");

endmodule

// File: bench/tb.sv
`timescale 1ns / 100ps
// Self-checking bench for priority_multi_server_dispatcher_top: random and directed
// requests, a built-in dispatch predictor and an in-order result check.
// Depends on msd_pkg and the dispatcher RTL only.
module tb;

   localparam int N_SRV  = msd_pkg::MAX_SERVERS_DEF;
   localparam int N_POOL = msd_pkg::POOL_DEPTH_DEF;
   localparam logic [31:0] T_MAX = 32'hFFFF_FFFF;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic                          req_func = msd_pkg::FUNC_SUBMIT;
   logic [msd_pkg::ARRIVAL_W-1:0] req_arrival_time = '0;
   logic [msd_pkg::SERVICE_W-1:0] req_service_time = '0;
   logic [msd_pkg::PRIO_W-1:0]    req_priority_req = '0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic                          rsp_status;
   logic [msd_pkg::INDEX_W-1:0]   rsp_job_index;
   logic [msd_pkg::START_W-1:0]   rsp_start_time;
   logic                          rsp_last;
   logic                          csr_wr_en = 1'b0;
   logic [msd_pkg::CSR_W-1:0]     csr_wr_data = '0;

   priority_multi_server_dispatcher_top uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_func(req_func),
      .req_arrival_time(req_arrival_time), .req_service_time(req_service_time),
      .req_priority_req(req_priority_req),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_status(rsp_status),
      .rsp_job_index(rsp_job_index), .rsp_start_time(rsp_start_time),
      .rsp_last(rsp_last),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   // 20 ns period clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ---------------------------------------------------------------------------
   // Dispatch predictor: its own copy of server times, waiting pool and counters.
   // ---------------------------------------------------------------------------
   logic [31:0]                   srv_free [N_SRV];
   logic                          slot_busy [N_POOL];
   logic [msd_pkg::PRIO_W-1:0]    slot_prio [N_POOL];
   logic [msd_pkg::INDEX_W-1:0]   slot_job [N_POOL];
   logic [msd_pkg::SERVICE_W-1:0] slot_svc [N_POOL];
   int unsigned                   slot_order [N_POOL];
   int unsigned                   order_ctr;
   logic [31:0]                   now_t;
   logic [msd_pkg::INDEX_W-1:0]   next_job;
   logic [msd_pkg::CSR_W-1:0]     servers_cfg;

   msd_pkg::result_type dispatch_q[$];   // results still owed by the block
   msd_pkg::item_type   request_q[$];    // requests waiting to be driven
   msd_pkg::item_type   cur_req;
   int                  error_count = 0;
   int                  src_idle_pct = 0;
   int                  sink_idle_pct = 0;
   logic [31:0]         arr_now = '0;

   function automatic logic [31:0] sat_add(logic [31:0] a, logic [15:0] b);
      logic [32:0] s;
      s = {1'b0, a} + 33'(b);
      return s[32] ? T_MAX : s[31:0];
   endfunction

   // earliest effective free server; lowest number wins a tie
   function automatic int earliest_server(output logic [31:0] when);
      int n, best;
      logic [31:0] t;
      n = (servers_cfg < 1) ? 1 : (servers_cfg > N_SRV) ? N_SRV : int'(servers_cfg);
      best = 0;
      when = '0;
      for (int i = 0; i < n; i++) begin
         t = (srv_free[i] < now_t) ? now_t : srv_free[i];
         if (i == 0 || t < when) begin
            when = t;
            best = i;
         end
      end
      return best;
   endfunction

   // highest priority waiting job; the most recent wins a tie
   function automatic int top_waiting_job();
      int best;
      best = -1;
      for (int i = 0; i < N_POOL; i++)
         if (slot_busy[i] && (best < 0 || slot_prio[i] > slot_prio[best] ||
             (slot_prio[i] == slot_prio[best] && slot_order[i] > slot_order[best])))
            best = i;
      return best;
   endfunction

   function automatic void owe_result(logic st, logic [15:0] job, logic [31:0] start);
      msd_pkg::result_type r;
      r.status = st;
      r.job_index = job;
      r.start_time = start;
      r.last = 1'b0;
      dispatch_q = {dispatch_q, r};
   endfunction

   function automatic void start_waiting_job(int slot);
      logic [31:0] t;
      int s;
      s = earliest_server(t);
      srv_free[s] = sat_add(t, slot_svc[slot]);
      now_t = t;
      owe_result(msd_pkg::STATUS_STARTED, slot_job[slot], t);
      slot_busy[slot] = 1'b0;
   endfunction

   function automatic void predict_dispatch(msd_pkg::item_type it);
      int n0, b, s, free_slot;
      logic [31:0] t;
      logic [15:0] job;
      n0 = dispatch_q.size();
      if (it.func == msd_pkg::FUNC_FLUSH) begin
         for (b = top_waiting_job(); b >= 0; b = top_waiting_job())
            start_waiting_job(b);
      end else begin
         job = next_job;
         next_job = next_job + 1'b1;
         // resolve every dispatch strictly before this arrival
         forever begin
            b = top_waiting_job();
            if (b < 0) break;
            void'(earliest_server(t));
            if (t >= it.arrival_time) break;
            start_waiting_job(b);
         end
         s = earliest_server(t);
         if (b < 0 && t < it.arrival_time) begin
            srv_free[s] = sat_add(it.arrival_time, it.service_time);
            now_t = it.arrival_time;
            owe_result(msd_pkg::STATUS_STARTED, job, it.arrival_time);
         end else begin
            free_slot = -1;
            for (int i = N_POOL - 1; i >= 0; i--)
               if (!slot_busy[i]) free_slot = i;
            if (free_slot < 0) begin
               owe_result(msd_pkg::STATUS_DROPPED, job, '0);
            end else begin
               order_ctr++;
               slot_busy[free_slot] = 1'b1;
               slot_prio[free_slot] = it.priority_req;
               slot_job[free_slot] = job;
               slot_svc[free_slot] = it.service_time;
               slot_order[free_slot] = order_ctr;
            end
         end
      end
      if (dispatch_q.size() > n0)
         dispatch_q[dispatch_q.size() - 1].last = 1'b1;
   endfunction

   // ---------------------------------------------------------------------------
   // Request driver: predict on each accepted request, then advance the queue.
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall)
            predict_dispatch(cur_req);
         if (!req_valid || !req_stall) begin
            if (request_q.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
               cur_req = request_q.pop_front();
               req_valid <= 1'b1;
               req_func <= cur_req.func;
               req_arrival_time <= cur_req.arrival_time;
               req_service_time <= cur_req.service_time;
               req_priority_req <= cur_req.priority_req;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Result monitor: random stall, compare each accepted result in order.
   // ---------------------------------------------------------------------------
   task automatic report_mismatch(string what);
      $display("mismatch at %0t: %s", $realtime, what);
      error_count++;
   endtask

   always @(posedge clock) begin
      msd_pkg::result_type e;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (dispatch_q.size() == 0) begin
               report_mismatch($sformatf("unexpected result job %0d", rsp_job_index));
            end else begin
               e = dispatch_q.pop_front();
               if (rsp_status !== e.status || rsp_job_index !== e.job_index ||
                   rsp_start_time !== e.start_time || rsp_last !== e.last)
                  report_mismatch($sformatf(
                     "got st %0b job %0d start %0d last %0b, want %0b %0d %0d %0b",
                     rsp_status, rsp_job_index, rsp_start_time, rsp_last,
                     e.status, e.job_index, e.start_time, e.last));
            end
         end
         rsp_stall <= ($urandom_range(99) < sink_idle_pct);
      end
   end

   // ---------------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------------
   function automatic void add_request(logic f, logic [31:0] a, logic [15:0] svc,
                                       logic [15:0] pri);
      msd_pkg::item_type it;
      it.func = f;
      it.arrival_time = a;
      it.service_time = svc;
      it.priority_req = pri;
      it.job_index = '0;
      request_q = {request_q, it};
   endfunction

   function automatic void add_flush();
      add_request(msd_pkg::FUNC_FLUSH, $urandom, 16'($urandom), 16'($urandom));
   endfunction

   // hold until everything sent is answered, then let a parked job settle
   task automatic wait_drained();
      int guard;
      while (request_q.size() > 0 || req_valid) @(posedge clock);
      while (dispatch_q.size() > 0) @(posedge clock);
      guard = 0;
      while (guard < 800) begin
         @(posedge clock);
         if (dispatch_q.size() > 0) guard = 0; else guard++;
      end
   endtask

   task automatic write_servers(logic [msd_pkg::CSR_W-1:0] v);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      servers_cfg = v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // one phase of random traffic: mostly bursts of jobs, now and then a flush
   task automatic random_traffic(int count, int unsigned max_step);
      int n, burst;
      logic [15:0] svc, pri;
      n = 0;
      while (n < count) begin
         burst = $urandom_range(1, 20);
         for (int j = 0; j < burst && n < count; j++) begin
            svc = ($urandom_range(99) < 3) ? 16'($urandom_range(1, 16'hFFFF))
                                           : 16'($urandom_range(1, 120));
            pri = ($urandom_range(1) == 0) ? 16'($urandom_range(0, 3)) : 16'($urandom);
            if ($urandom_range(99) < 8 && arr_now > 200) begin
               // out-of-order arrival
               add_request(msd_pkg::FUNC_SUBMIT, arr_now - $urandom_range(1, 200),
                           svc, pri);
            end else begin
               if (T_MAX - arr_now < max_step) arr_now = T_MAX;
               else arr_now = arr_now + $urandom_range(0, max_step);
               add_request(msd_pkg::FUNC_SUBMIT, arr_now, svc, pri);
            end
            n++;
            if (n == count / 2 && count > 40) begin
               // sender pause: let every owed result arrive first
               wait_drained();
            end
         end
         if ($urandom_range(2) == 0) begin
            add_flush();
            n++;
         end
      end
   endtask

   initial begin
      logic [msd_pkg::CSR_W-1:0] cfg_list [6];
      cfg_list = '{3'd4, 3'd0, 3'd7, 3'd2, 3'd3, 3'd1};
      for (int i = 0; i < N_SRV; i++) srv_free[i] = '0;
      for (int i = 0; i < N_POOL; i++) begin
         slot_busy[i] = 1'b0;
         slot_order[i] = 0;
      end
      order_ctr = 0;
      now_t = '0;
      next_job = '0;
      servers_cfg = 3'd1;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: zero service, priority extremes, ties, start-at-arrival, drop
      add_request(msd_pkg::FUNC_SUBMIT, 32'd0, 16'd0, 16'hFFFF);
      add_request(msd_pkg::FUNC_SUBMIT, 32'd0, 16'd50, 16'h0000);
      add_request(msd_pkg::FUNC_SUBMIT, 32'd1, 16'd5, 16'd7);
      add_request(msd_pkg::FUNC_SUBMIT, 32'd1, 16'd5, 16'd7);
      add_request(msd_pkg::FUNC_SUBMIT, 32'd2, 16'd5, 16'hFFFF);
      add_request(msd_pkg::FUNC_SUBMIT, 32'd200, 16'd10, 16'd1);
      add_flush();
      add_flush();
      for (int i = 0; i < 17; i++)
         add_request(msd_pkg::FUNC_SUBMIT, 32'd300, 16'd1, i[15:0]);
      add_request(msd_pkg::FUNC_SUBMIT, 32'd400, 16'd3, 16'd9);
      add_flush();
      arr_now = 32'd500;

      for (int ph = 0; ph < 6; ph++) begin
         wait_drained();
         write_servers(cfg_list[ph]);
         case (ph / 2)
            0: begin src_idle_pct = 14; sink_idle_pct = 85; end
            1: begin src_idle_pct = 85; sink_idle_pct = 14; end
            default: begin src_idle_pct = 0; sink_idle_pct = 0; end
         endcase
         // last phase takes large time steps so the high arrival bits move
         random_traffic(70, (ph == 5) ? 32'h0400_0000 : 32'd40);
      end

      // saturate server times near the top of the time range
      add_request(msd_pkg::FUNC_SUBMIT, 32'hFFFF_FF00, 16'hFFFF, 16'd1);
      add_request(msd_pkg::FUNC_SUBMIT, T_MAX, 16'hFFFF, 16'd2);
      add_request(msd_pkg::FUNC_SUBMIT, T_MAX, 16'd1, 16'd3);
      add_flush();

      wait_drained();
      if (error_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   // run limit
   initial begin
      #60_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

// File: sim.f
design/msd_pkg.sv
design/msd_ram.sv
design/msd_front.sv
design/msd_back.sv
design/priority_multi_server_dispatcher_top.sv
bench/tb.sv
